@@ design/lwdp_pkg.sv @@
// Shared constants, types and register codes for the linear weight density profile block.
// No dependencies; every other design file refers to this package by scoped names.
`default_nettype none

package lwdp_pkg;

  localparam int BINS_DEFAULT  = 64;
  localparam int FRAC_DEFAULT  = 16;
  localparam int FRAC_MAX      = 24;
  localparam int BIN_W         = 6;
  localparam int ACC_W         = 32;
  localparam int DENS_W        = 48;
  localparam int WEIGHT_W      = FRAC_MAX + 1;
  localparam int Q_DEPTH       = 4;
  localparam int Q_CNT_W       = 3;
  localparam int CFG_IDX_W     = 2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_GRID_OFFSET     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INV_SPACING     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DENSITY_SCALE   = 2'd2;

  localparam logic [30:0] GRID_OFFSET_RST   = 31'd4155679;
  localparam logic [31:0] INV_SPACING_RST   = 32'd32555;
  localparam logic [31:0] DENSITY_SCALE_RST = 32'd65536;

  typedef logic [WEIGHT_W-1:0]      weight_t;
  typedef logic [BIN_W-1:0]         bin_t;
  typedef logic [ACC_W-1:0]         acc_t;
  typedef logic signed [DENS_W-1:0] dens_t;
  typedef logic [Q_CNT_W:0]         qfill_t;

  localparam dens_t DENS_MAX = {1'b0, {(DENS_W-1){1'b1}}};
  localparam dens_t DENS_MIN = {1'b1, {(DENS_W-1){1'b0}}};

  // One deposit: a lower bin and the bin above it, each with its own enable and weight.
  typedef struct packed {
    logic    wr_lo;
    logic    wr_hi;
    bin_t    addr_lo;
    weight_t w_lo;
    weight_t w_hi;
    logic    frame_end;
  } cmd_t;

endpackage

`default_nettype wire

@@ design/lwdp_front.sv @@
// Front end: takes particle positions, maps them onto the grid and classifies the deposit.
// Depends on lwdp_pkg; feeds lwdp_cmdq, whose fill level it uses for flow control.
`default_nettype none

module lwdp_front #(
  parameter int BINS          = lwdp_pkg::BINS_DEFAULT,
  parameter int FRACTION_BITS = lwdp_pkg::FRAC_DEFAULT
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      push,
  output logic                           full,
  input  wire logic signed [31:0]        z_position,
  input  wire logic                      frame_end,
  input  wire logic [30:0]               grid_offset,
  input  wire logic [31:0]               inverse_spacing,
  input  wire logic [lwdp_pkg::Q_CNT_W-1:0] q_count,
  output logic                           cmd_push,
  output lwdp_pkg::cmd_t                 cmd
);

  localparam int SH = 32 - FRACTION_BITS;

  logic               accept;
  logic signed [32:0] pos_sum;
  logic               a_valid;
  logic signed [32:0] a_pos;
  logic               a_fe;
  logic               b_valid;
  logic [63:0]        b_prod;
  logic               b_neg;
  logic               b_fe;
  lwdp_pkg::qfill_t   inflight;
  logic [31:0]        idx;
  logic [FRACTION_BITS-1:0] frac;
  logic [FRACTION_BITS:0]   one_minus;

  // Items in the two stages always reach the queue, so room is reserved for them here.
  assign inflight = lwdp_pkg::qfill_t'(q_count) + lwdp_pkg::qfill_t'(a_valid)
                    + lwdp_pkg::qfill_t'(b_valid);
  assign full     = inflight >= lwdp_pkg::qfill_t'(lwdp_pkg::Q_DEPTH);
  assign accept   = push & ~full;

  assign pos_sum = $signed({z_position[31], z_position}) + $signed({2'b00, grid_offset});

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
    end else begin
      a_valid <= accept;
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_pos <= pos_sum;
      a_fe  <= frame_end;
    end
    if (a_valid) begin
      b_prod <= a_pos[31:0] * inverse_spacing;
      b_neg  <= a_pos[32];
      b_fe   <= a_fe;
    end
  end

  assign idx       = b_prod[63:32];
  assign frac      = b_prod[31:SH];
  assign one_minus = {1'b1, {FRACTION_BITS{1'b0}}} - {1'b0, frac};

  // Index zero feeds only the upper bin; the next-to-last index feeds only itself.
  always_comb begin
    cmd.wr_lo     = ~b_neg && (idx != 32'd0) && (idx <= 32'(BINS - 2));
    cmd.wr_hi     = ~b_neg && (idx < 32'(BINS - 2));
    cmd.addr_lo   = idx[lwdp_pkg::BIN_W-1:0];
    cmd.w_lo      = lwdp_pkg::weight_t'(one_minus);
    cmd.w_hi      = lwdp_pkg::weight_t'(frac);
    cmd.frame_end = b_fe;
  end

  assign cmd_push = b_valid;

endmodule

`default_nettype wire

@@ design/lwdp_cmdq.sv @@
// Short command queue between the front end and the accumulator back end.
// Depends on lwdp_pkg for the command type and the queue depth.
`default_nettype none

module lwdp_cmdq (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          wr,
  input  wire lwdp_pkg::cmd_t                wr_cmd,
  input  wire logic                          rd,
  output lwdp_pkg::cmd_t                     head,
  output logic                               q_empty,
  output logic [lwdp_pkg::Q_CNT_W-1:0]       count
);

  localparam int PW = $clog2(lwdp_pkg::Q_DEPTH);

  lwdp_pkg::cmd_t q_mem [lwdp_pkg::Q_DEPTH];
  logic [PW-1:0]  wptr;
  logic [PW-1:0]  rptr;
  logic           do_rd;

  assign q_empty = (count == '0);
  assign head    = q_mem[rptr];
  assign do_rd   = rd & ~q_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (wr) begin
        wptr <= (wptr == PW'(lwdp_pkg::Q_DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (do_rd) begin
        rptr <= (rptr == PW'(lwdp_pkg::Q_DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      count <= count + lwdp_pkg::Q_CNT_W'(wr) - lwdp_pkg::Q_CNT_W'(do_rd);
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      q_mem[wptr] <= wr_cmd;
    end
  end

endmodule

`default_nettype wire

@@ design/lwdp_back.sv @@
// Back end: accumulator memory, two-bin deposits, and the frame-end scale and emit walk.
// Depends on lwdp_pkg; takes commands from lwdp_cmdq and drives the result register.
`default_nettype none

module lwdp_back #(
  parameter int BINS          = lwdp_pkg::BINS_DEFAULT,
  parameter int FRACTION_BITS = lwdp_pkg::FRAC_DEFAULT
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic [31:0]         density_scale,
  input  wire lwdp_pkg::cmd_t      head,
  input  wire logic                q_empty,
  output logic                     q_pop,
  input  wire logic                pop,
  output logic                     empty,
  output lwdp_pkg::bin_t           bin_index,
  output lwdp_pkg::dens_t          density,
  output logic                     last_bin
);

  localparam int AW = $clog2(BINS);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DEP_LO = 3'd1;
  localparam logic [2:0] S_DEP_HI = 3'd2;
  localparam logic [2:0] S_E_RD   = 3'd3;
  localparam logic [2:0] S_E_MUL  = 3'd4;
  localparam logic [2:0] S_E_SAT  = 3'd5;
  localparam logic [2:0] S_E_OUT  = 3'd6;

  // Which result of the current bin goes out next.
  localparam logic [1:0] SUB_FIRST  = 2'd0;
  localparam logic [1:0] SUB_SECOND = 2'd1;
  localparam logic [1:0] SUB_CUR    = 2'd2;
  localparam logic [1:0] SUB_LAST   = 2'd3;

  lwdp_pkg::acc_t  acc_mem [BINS];
  logic [BINS-1:0] acc_vld;

  logic [2:0]      state;
  lwdp_pkg::cmd_t  cmd;
  logic [AW-1:0]   e_bin;
  logic [1:0]      sub;
  logic [AW-1:0]   ra_a;
  logic [AW-1:0]   ra_b;
  logic            rd_en;
  lwdp_pkg::acc_t  rd_a;
  lwdp_pkg::acc_t  rd_b;
  logic            rd_av;
  logic            rd_bv;
  lwdp_pkg::acc_t  acc_a;
  lwdp_pkg::acc_t  acc_b;
  logic            mem_we;
  logic [AW-1:0]   mem_wa;
  lwdp_pkg::acc_t  mem_wd;
  logic [63:0]     eprod;
  logic [63:0]     p_shift;
  lwdp_pkg::dens_t p_sat;
  lwdp_pkg::dens_t d_cur;
  lwdp_pkg::dens_t d_prev;
  logic            out_valid;
  logic            slot_free;
  logic            load;
  lwdp_pkg::bin_t  nx_bin;
  lwdp_pkg::dens_t nx_dens;
  logic            nx_last;
  logic            bin_done;

  function automatic lwdp_pkg::acc_t acc_add(lwdp_pkg::acc_t a, lwdp_pkg::weight_t w);
    logic [lwdp_pkg::ACC_W:0] s;
    s = {1'b0, a} + (lwdp_pkg::ACC_W + 1)'(w);
    return s[lwdp_pkg::ACC_W] ? '1 : s[lwdp_pkg::ACC_W-1:0];
  endfunction

  // Linear extrapolation 2*a - b, clamped to the signed result range.
  function automatic lwdp_pkg::dens_t extrap(lwdp_pkg::dens_t a, lwdp_pkg::dens_t b);
    logic signed [lwdp_pkg::DENS_W+1:0] wa;
    logic signed [lwdp_pkg::DENS_W+1:0] wb;
    logic signed [lwdp_pkg::DENS_W+1:0] v;
    wa = {{2{a[lwdp_pkg::DENS_W-1]}}, a};
    wb = {{2{b[lwdp_pkg::DENS_W-1]}}, b};
    v  = (wa <<< 1) - wb;
    if (v > $signed({{2{1'b0}}, lwdp_pkg::DENS_MAX})) begin
      return lwdp_pkg::DENS_MAX;
    end else if (v < $signed({{2{1'b1}}, lwdp_pkg::DENS_MIN})) begin
      return lwdp_pkg::DENS_MIN;
    end
    return v[lwdp_pkg::DENS_W-1:0];
  endfunction

  assign q_pop = (state == S_IDLE) & ~q_empty;
  assign rd_en = q_pop | (state == S_E_RD);

  always_comb begin
    if (state == S_IDLE) begin
      ra_a = head.addr_lo[AW-1:0];
    end else begin
      ra_a = e_bin;
    end
    ra_b = ra_a + 1'b1;
  end

  assign acc_a = rd_av ? rd_a : '0;
  assign acc_b = rd_bv ? rd_b : '0;

  always_comb begin
    mem_we = 1'b0;
    mem_wa = cmd.addr_lo[AW-1:0];
    mem_wd = acc_add(acc_a, cmd.w_lo);
    case (state)
      S_DEP_LO: begin
        mem_we = cmd.wr_lo;
      end
      S_DEP_HI: begin
        mem_we = cmd.wr_hi;
        mem_wa = cmd.addr_lo[AW-1:0] + 1'b1;
        mem_wd = acc_add(acc_b, cmd.w_hi);
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  // Read-first memory; the walk reads a bin and drops its valid bit in the same cycle.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      acc_mem[mem_wa] <= mem_wd;
    end
    if (rd_en) begin
      rd_a <= acc_mem[ra_a];
      rd_b <= acc_mem[ra_b];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc_vld <= '0;
      rd_av   <= 1'b0;
      rd_bv   <= 1'b0;
    end else begin
      if (rd_en) begin
        rd_av <= acc_vld[ra_a];
        rd_bv <= acc_vld[ra_b];
      end
      if (mem_we) begin
        acc_vld[mem_wa] <= 1'b1;
      end else if (state == S_E_RD) begin
        acc_vld[e_bin] <= 1'b0;
      end
    end
  end

  assign p_shift = eprod >> FRACTION_BITS;
  assign p_sat   = (p_shift > 64'(lwdp_pkg::DENS_MAX)) ? lwdp_pkg::DENS_MAX
                                                       : p_shift[lwdp_pkg::DENS_W-1:0];

  always_comb begin
    case (sub)
      SUB_FIRST: begin
        nx_bin  = '0;
        nx_dens = extrap(d_prev, d_cur);
        nx_last = 1'b0;
      end
      SUB_SECOND: begin
        nx_bin  = lwdp_pkg::bin_t'(1);
        nx_dens = d_prev;
        nx_last = 1'b0;
      end
      SUB_CUR: begin
        nx_bin  = lwdp_pkg::bin_t'(e_bin);
        nx_dens = d_cur;
        nx_last = 1'b0;
      end
      SUB_LAST: begin
        nx_bin  = lwdp_pkg::bin_t'(BINS - 1);
        nx_dens = extrap(d_cur, d_prev);
        nx_last = 1'b1;
      end
      default: begin
        nx_bin  = '0;
        nx_dens = '0;
        nx_last = 1'b0;
      end
    endcase
  end

  assign slot_free = ~out_valid | pop;
  assign load      = (state == S_E_OUT) && (e_bin != AW'(1)) && slot_free;
  assign bin_done  = (sub == SUB_LAST) ||
                     ((sub == SUB_CUR) && (e_bin != AW'(BINS - 2)));

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      e_bin     <= '0;
      sub       <= SUB_FIRST;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (~q_empty) begin
            state <= S_DEP_LO;
          end
        end
        S_DEP_LO: begin
          state <= S_DEP_HI;
        end
        S_DEP_HI: begin
          if (cmd.frame_end) begin
            e_bin <= AW'(1);
            state <= S_E_RD;
          end else begin
            state <= S_IDLE;
          end
        end
        S_E_RD: begin
          state <= S_E_MUL;
        end
        S_E_MUL: begin
          state <= S_E_SAT;
        end
        S_E_SAT: begin
          sub   <= (e_bin == AW'(2)) ? SUB_FIRST : SUB_CUR;
          state <= S_E_OUT;
        end
        S_E_OUT: begin
          if (e_bin == AW'(1)) begin
            // Bin one is only held until bin two is known.
            e_bin <= e_bin + 1'b1;
            state <= S_E_RD;
          end else if (slot_free) begin
            if (bin_done) begin
              if (sub == SUB_LAST) begin
                state <= S_IDLE;
              end else begin
                e_bin <= e_bin + 1'b1;
                state <= S_E_RD;
              end
            end else begin
              sub <= sub + 1'b1;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cmd <= head;
    end
    if (state == S_E_MUL) begin
      eprod <= acc_a * density_scale;
    end
    if (state == S_E_SAT) begin
      d_prev <= d_cur;
      d_cur  <= p_sat;
    end
    if (load) begin
      bin_index <= nx_bin;
      density   <= nx_dens;
      last_bin  <= nx_last;
    end
  end

  assign empty = ~out_valid;

endmodule

`default_nettype wire

@@ design/linear_weight_density_profile.sv @@
// Top level of the linear weight density profile: configuration registers and the
// front end, command queue and back end. Depends on lwdp_pkg, lwdp_front, lwdp_cmdq, lwdp_back.
//
//   Channel   Handshake              Payload
//   input     push / full            z_position, frame_end
//   result    empty / pop            bin_index, density, last_bin
//   config    cfg_valid / cfg_ready  cfg_index, cfg_data
//
// The front end takes one position per cycle until the command queue and its two
// pipeline stages together hold four items; full then stays high until the back end pops.
// For each particle the back end reads both bins, then writes the lower and the upper bin.
// A frame end adds a walk over each interior bin (read, multiply, saturate,
// emit), with two extra result transfers at bin two and one at the last interior bin.
// A result that is not popped holds the walk; reset restores register defaults and
// clears every accumulator at once through its valid bit.
`default_nettype none

module linear_weight_density_profile #(
  parameter int BINS          = lwdp_pkg::BINS_DEFAULT,
  parameter int FRACTION_BITS = lwdp_pkg::FRAC_DEFAULT
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              push,
  output logic                                   full,
  input  wire logic signed [31:0]                z_position,
  input  wire logic                              frame_end,
  output logic                                   empty,
  input  wire logic                              pop,
  output logic [lwdp_pkg::BIN_W-1:0]             bin_index,
  output logic signed [lwdp_pkg::DENS_W-1:0]     density,
  output logic                                   last_bin,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [lwdp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [31:0]                       cfg_data
);

  logic [30:0]                  grid_offset;
  logic [31:0]                  inverse_spacing;
  logic [31:0]                  density_scale;
  logic                         cmd_push;
  lwdp_pkg::cmd_t               cmd_in;
  lwdp_pkg::cmd_t               cmd_head;
  logic                         q_empty;
  logic                         q_pop;
  logic [lwdp_pkg::Q_CNT_W-1:0] q_count;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_offset     <= lwdp_pkg::GRID_OFFSET_RST;
      inverse_spacing <= lwdp_pkg::INV_SPACING_RST;
      density_scale   <= lwdp_pkg::DENSITY_SCALE_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        lwdp_pkg::REG_GRID_OFFSET:   grid_offset     <= cfg_data[30:0];
        lwdp_pkg::REG_INV_SPACING:   inverse_spacing <= cfg_data;
        lwdp_pkg::REG_DENSITY_SCALE: density_scale   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  lwdp_front #(
    .BINS          (BINS),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_front (
    .clk             (clk),
    .rst             (rst),
    .push            (push),
    .full            (full),
    .z_position      (z_position),
    .frame_end       (frame_end),
    .grid_offset     (grid_offset),
    .inverse_spacing (inverse_spacing),
    .q_count         (q_count),
    .cmd_push        (cmd_push),
    .cmd             (cmd_in)
  );

  lwdp_cmdq u_cmdq (
    .clk     (clk),
    .rst     (rst),
    .wr      (cmd_push),
    .wr_cmd  (cmd_in),
    .rd      (q_pop),
    .head    (cmd_head),
    .q_empty (q_empty),
    .count   (q_count)
  );

  lwdp_back #(
    .BINS          (BINS),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .density_scale (density_scale),
    .head          (cmd_head),
    .q_empty       (q_empty),
    .q_pop         (q_pop),
    .pop           (pop),
    .empty         (empty),
    .bin_index     (bin_index),
    .density       (density),
    .last_bin      (last_bin)
  );

endmodule

`default_nettype wire

@@ design/lwdp_checker.sv @@
// Port-level checks on the linear weight density profile, bound to its top level.
// Depends on lwdp_pkg and on the port list of linear_weight_density_profile.
`default_nettype none

module lwdp_checker #(
  parameter int BINS = lwdp_pkg::BINS_DEFAULT
) (
  input wire logic                           clk,
  input wire logic                           rst,
  input wire logic                           full,
  input wire logic                           empty,
  input wire logic                           pop,
  input wire logic [lwdp_pkg::BIN_W-1:0]     bin_index,
  input wire logic [lwdp_pkg::DENS_W-1:0]    density,
  input wire logic                           last_bin
);

  // After reset nothing is waiting and the input side is open.
  a_reset_idle: assert property (@(posedge clk) rst |=> (empty && !full))
    else $error("result pending or input blocked after reset");

  // A waiting result does not change until it is taken.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(bin_index) && $stable(density)
                          && $stable(last_bin)))
    else $error("waiting result changed before transfer");

  // The final bin of a profile is always the top bin.
  a_last_is_top: assert property (@(posedge clk) disable iff (rst)
    (!empty && last_bin) |-> (bin_index == lwdp_pkg::BIN_W'(BINS - 1)))
    else $error("last_bin set on a bin other than the top one");

  // Bins follow one another in order when the next one is ready right away.
  a_in_order: assert property (@(posedge clk) disable iff (rst)
    (pop && !empty && !last_bin) |=>
      (empty || (bin_index == lwdp_pkg::BIN_W'($past(bin_index) + 1'b1))))
    else $error("bins out of order");

  // Interior densities come from unsigned sums and cannot be negative.
  a_interior_sign: assert property (@(posedge clk) disable iff (rst)
    (!empty && (bin_index != '0) && !last_bin) |-> !density[lwdp_pkg::DENS_W-1])
    else $error("negative interior density");

endmodule

bind linear_weight_density_profile lwdp_checker #(
  .BINS (BINS)
) u_lwdp_checker (
  .clk       (clk),
  .rst       (rst),
  .full      (full),
  .empty     (empty),
  .pop       (pop),
  .bin_index (bin_index),
  .density   (density),
  .last_bin  (last_bin)
);

`default_nettype wire

@@ dv/tb_linear_weight_density_profile.sv @@
// Testbench for linear_weight_density_profile: random and directed particle positions,
// frame-end profile checking and register sweeps. Depends on lwdp_pkg and the block RTL.
`default_nettype none

module tb_linear_weight_density_profile;

  localparam int NBINS = lwdp_pkg::BINS_DEFAULT;
  localparam int FRAC  = lwdp_pkg::FRAC_DEFAULT;
  localparam logic [lwdp_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam longint DENS_TOP = (longint'(1) <<< 47) - 1;
  localparam longint DENS_BOT = -DENS_TOP - 1;

  typedef struct {
    lwdp_pkg::bin_t  bin;
    lwdp_pkg::dens_t dens;
    logic            last;
  } bin_result_t;

  // Tracks the accumulators and registers, and holds the profile bins still to come.
  class profile_scoreboard;
    logic [30:0] offset;
    logic [31:0] inv_spacing;
    logic [31:0] scale;
    logic [31:0] acc [NBINS];
    bin_result_t expected_bins [$];
    int errors;

    function new();
      offset      = lwdp_pkg::GRID_OFFSET_RST;
      inv_spacing = lwdp_pkg::INV_SPACING_RST;
      scale       = lwdp_pkg::DENSITY_SCALE_RST;
      foreach (acc[i]) acc[i] = '0;
      errors = 0;
    endfunction

    function void write_reg(logic [lwdp_pkg::CFG_IDX_W-1:0] idx, logic [31:0] data);
      case (idx)
        lwdp_pkg::REG_GRID_OFFSET: begin
          offset = data[30:0];
        end
        lwdp_pkg::REG_INV_SPACING: begin
          inv_spacing = data;
        end
        lwdp_pkg::REG_DENSITY_SCALE: begin
          scale = data;
        end
        default: begin
        end
      endcase
    endfunction

    function void add_weight(int unsigned b, logic [63:0] w);
      logic [63:0] s;
      s = {32'd0, acc[b]} + w;
      acc[b] = (s > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    function longint clip48(longint v);
      if (v > DENS_TOP) return DENS_TOP;
      if (v < DENS_BOT) return DENS_BOT;
      return v;
    endfunction

    function void deposit(logic signed [31:0] z, logic fe);
      longint      pos;
      logic [63:0] prod;
      logic [63:0] bin_no;
      logic [63:0] one;
      logic [63:0] frac;
      logic [63:0] p;
      longint      prof [NBINS];
      bin_result_t r;
      int          i;
      pos = longint'(z) + longint'(offset);
      if (pos >= 0) begin
        prod   = 64'(pos) * {32'd0, inv_spacing};
        bin_no = prod >> 32;
        one    = 64'd1 << FRAC;
        frac   = (prod >> (32 - FRAC)) & (one - 64'd1);
        // Bin zero never collects weight; the next to last bin keeps only its own share.
        if (bin_no == 0) begin
          add_weight(1, frac);
        end else if (bin_no == NBINS - 2) begin
          add_weight(int'(bin_no), one - frac);
        end else if (bin_no < NBINS - 2) begin
          add_weight(int'(bin_no), one - frac);
          add_weight(int'(bin_no) + 1, frac);
        end
      end
      if (!fe) return;
      for (i = 1; i < NBINS - 1; i++) begin
        p = ({32'd0, acc[i]} * {32'd0, scale}) >> FRAC;
        if (p > DENS_TOP) p = DENS_TOP;
        prof[i] = longint'(p);
      end
      // The end bins are extrapolated from their two inner neighbors.
      prof[0]         = clip48(2 * prof[1] - prof[2]);
      prof[NBINS - 1] = clip48(2 * prof[NBINS - 2] - prof[NBINS - 3]);
      for (i = 0; i < NBINS; i++) begin
        r.bin  = lwdp_pkg::bin_t'(i);
        r.dens = prof[i][lwdp_pkg::DENS_W-1:0];
        r.last = (i == NBINS - 1);
        expected_bins.insert(expected_bins.size(), r);
      end
      foreach (acc[j]) acc[j] = '0;
    endfunction

    function void check_bin(lwdp_pkg::bin_t b, lwdp_pkg::dens_t d, logic l);
      bin_result_t e;
      if (expected_bins.size() == 0) begin
        $error("result for bin %0d arrived with no expectation pending", b);
        errors++;
        return;
      end
      e = expected_bins.pop_front();
      if (b !== e.bin) begin
        $error("bin_index mismatch: expected %0d, actual %0d", e.bin, b);
        errors++;
      end
      if (d !== e.dens) begin
        $error("density mismatch at bin %0d: expected %0d, actual %0d", e.bin, e.dens, d);
        errors++;
      end
      if (l !== e.last) begin
        $error("last_bin mismatch at bin %0d: expected %0d, actual %0d", e.bin, e.last, l);
        errors++;
      end
    endfunction
  endclass

  logic              clk;
  logic              rst;
  logic              push;
  logic              full;
  logic signed [31:0] z_position;
  logic              frame_end;
  logic              empty;
  logic              pop;
  lwdp_pkg::bin_t    bin_index;
  lwdp_pkg::dens_t   density;
  logic              last_bin;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [lwdp_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [31:0]       cfg_data;
  bit                steady;

  profile_scoreboard sb = new();

  linear_weight_density_profile DUT (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .z_position (z_position),
    .frame_end  (frame_end),
    .empty      (empty),
    .pop        (pop),
    .bin_index  (bin_index),
    .density    (density),
    .last_bin   (last_bin),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #100_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Result side: pop at random, or always while steady; check every transfer.
  initial begin
    pop = 1'b0;
    forever begin
      @(negedge clk);
      pop <= steady || ($urandom_range(99) >= 29);
      @(posedge clk);
      if (pop && !empty) sb.check_bin(bin_index, density, last_bin);
    end
  end

  // Position that lands at bin b with fraction fr under the current registers.
  function automatic logic signed [31:0] z_at(int b, int fr);
    longint t;
    if (sb.inv_spacing == 0) return $urandom;
    t = ((longint'(b) <<< 32) + (longint'(fr) <<< 16)) / longint'({32'd0, sb.inv_spacing})
        - longint'(sb.offset);
    if (t != longint'($signed(t[31:0]))) return $urandom;
    return t[31:0];
  endfunction

  function automatic logic signed [31:0] pick_z();
    int r;
    r = $urandom_range(99);
    if (r >= 85) return $urandom;
    if (r >= 75) return 32'(-longint'(sb.offset) + longint'($urandom_range(4)) - 2);
    return z_at($urandom_range(NBINS - 1), $urandom_range(16'hFFFF));
  endfunction

  task automatic send_particle(logic signed [31:0] z, logic fe);
    while (!steady && $urandom_range(99) < 29) begin
      push <= 1'b0;
      @(negedge clk);
    end
    push       <= 1'b1;
    z_position <= z;
    frame_end  <= fe;
    do @(posedge clk); while (full);
    sb.deposit(z, fe);
    @(negedge clk);
  endtask

  task automatic write_reg(logic [lwdp_pkg::CFG_IDX_W-1:0] idx, logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, data);
    @(negedge clk);
  endtask

  task automatic configure(logic [31:0] o, logic [31:0] iv, logic [31:0] sc);
    write_reg(lwdp_pkg::REG_GRID_OFFSET, o);
    write_reg(lwdp_pkg::REG_INV_SPACING, iv);
    write_reg(lwdp_pkg::REG_DENSITY_SCALE, sc);
    cfg_valid <= 1'b0;
  endtask

  // Waits for every expected bin, then lets the pipeline settle.
  task automatic drain(int tail);
    push <= 1'b0;
    while (sb.expected_bins.size() != 0) @(posedge clk);
    repeat (tail) @(negedge clk);
  endtask

  initial begin
    int n;
    rst        = 1'b1;
    push       = 1'b0;
    z_position = '0;
    frame_end  = 1'b0;
    cfg_valid  = 1'b0;
    cfg_index  = lwdp_pkg::REG_GRID_OFFSET;
    cfg_data   = '0;
    steady     = 1'b0;
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Edges of the grid under the reset registers.
    send_particle(z_at(0, 0) - 1, 1'b0);
    send_particle(z_at(0, 0), 1'b0);
    send_particle(z_at(0, 16'h8000), 1'b0);
    send_particle(z_at(1, 0), 1'b0);
    send_particle(z_at(30, 16'h4000), 1'b0);
    send_particle(z_at(62, 16'h1234), 1'b0);
    send_particle(z_at(63, 16'h0010), 1'b0);
    send_particle(32'sh7FFF_FFFF, 1'b0);
    send_particle(32'sh8000_0000, 1'b0);
    send_particle(z_at(10, 16'hFFFF), 1'b1);
    drain(20);

    // With 1/64 bin per nm, multiples of 64 have a zero fraction.
    write_reg(REG_UNUSED, $urandom);
    configure(32'd0, 32'h0400_0000, 32'hFFFF_FFFF);
    send_particle(0, 1'b0);
    send_particle(64, 1'b0);
    send_particle(64 * 62, 1'b0);
    send_particle(64 * 5 + 32, 1'b0);
    send_particle(64 * 63, 1'b0);
    send_particle(-1, 1'b0);
    send_particle(64 * 40, 1'b1);
    drain(20);

    for (int ph = 0; ph < 6; ph++) begin
      steady <= (ph == 0);
      case (ph)
        0: configure(lwdp_pkg::GRID_OFFSET_RST, lwdp_pkg::INV_SPACING_RST,
                     lwdp_pkg::DENSITY_SCALE_RST);
        1: configure($urandom, $urandom, $urandom);
        2: configure(32'h7FFF_FFFF, $urandom_range(200, 40), $urandom);
        3: configure(32'd0, 32'hFFFF_FFFF, $urandom_range(65536));
        4: configure($urandom, 32'd0, 32'd0);
        default: configure($urandom_range(1 << 24), $urandom_range(1 << 20), $urandom);
      endcase
      n = (ph == 4) ? 15 : 38;
      for (int k = 0; k < n; k++) begin
        send_particle(pick_z(), (k == n - 1) || ($urandom_range(11) == 0));
      end
      drain(20);
    end

    repeat (50) @(negedge clk);
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

`default_nettype wire

@@ filelist.f @@
design/lwdp_pkg.sv
design/lwdp_front.sv
design/lwdp_cmdq.sv
design/lwdp_back.sv
design/linear_weight_density_profile.sv
design/lwdp_checker.sv
dv/tb_linear_weight_density_profile.sv
